@@ hdl/window_summary_aggregator_assert.svh @@
// assertion macros for the window summary aggregator checker
// no dependencies
`ifndef WINDOW_SUMMARY_AGGREGATOR_ASSERT_SVH
`define WINDOW_SUMMARY_AGGREGATOR_ASSERT_SVH
// implication checked on every clock, off during reset
`define WSA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define WSA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ hdl/wsa_pkg.sv @@
// shared types and constants for the window summary aggregator
// no dependencies
package wsa_pkg;
  localparam logic [1:0] MODE_MEAN   = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;
  localparam logic [1:0] MODE_SUM    = 2'd2;
  localparam logic [1:0] MODE_COUNT  = 2'd3;
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_LEN  = 1'b1;
  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  // one closed window handed from front to back
  typedef struct packed {
    logic [31:0]        window_index;
    logic signed [47:0] sum;
    logic [31:0]        count;
    logic [1:0]         mode;
    logic               bank;
  } close_job_t;
endpackage

@@ hdl/wsa_divider.sv @@
// restoring divider: signed 48-bit dividend by unsigned 32-bit divisor
// uses wsa_pkg nothing; one quotient bit per cycle, truncates toward zero
module wsa_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] dividend,
  input  logic [31:0]        divisor,
  output logic               done,
  output logic signed [47:0] quotient
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic        neg_r, busy_r;
  logic [5:0]  cnt_r;
  logic [32:0] trial;

  always_comb begin
    trial = {rem_r[31:0], q_r[47]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = trial - {1'b0, dvs_r};
      q_nxt = {q_r[46:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt = {q_r[46:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd48;
        q_r <= dividend[47] ? 48'(-dividend) : dividend;
        neg_r <= dividend[47];
        dvs_r <= divisor;
        rem_r <= '0;
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = neg_r ? 48'(-q_r) : q_r;
endmodule

@@ hdl/wsa_front.sv @@
// front end: window classification, sum/count accumulation, value store writes
// uses wsa_pkg
module wsa_front #(
  parameter int MAX_WINDOW = 256,
  localparam int AW = $clog2(MAX_WINDOW)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [30:0]             cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [31:0]             in_position,
  input  logic signed [31:0]      in_sample_value,
  input  logic                    in_is_missing,
  output logic                    job_valid,
  output wsa_pkg::close_job_t     job,
  input  logic                    job_ready,
  output logic                    st_we,
  output logic                    st_bank,
  output logic [AW-1:0]           st_addr,
  output logic signed [31:0]      st_data
);
  typedef enum logic [1:0] {F_IDLE, F_DIV, F_APPLY} fstate_t;
  fstate_t state_r;
  logic [1:0]  mode_r;
  logic [30:0] len_r;
  logic signed [47:0] sum_r;
  logic [31:0] cnt_r, cur_win_r;
  logic open_r, bank_r;
  logic kind_r, miss_r;
  logic signed [31:0] val_r;
  logic [31:0] w_r, dq_r, dr_r;
  logic [5:0]  dc_r;
  logic [32:0] dtrial;
  logic signed [48:0] sum_ext;
  logic signed [47:0] sum_sat;
  logic close_now;

  // window number by bit-serial division of position-1 by length
  assign dtrial = {dr_r, dq_r[31]};
  assign sum_ext = 49'(sum_r) + 49'(val_r);
  assign sum_sat = (sum_ext > 49'(wsa_pkg::SUM_MAX)) ? wsa_pkg::SUM_MAX :
                   (sum_ext < 49'(wsa_pkg::SUM_MIN)) ? wsa_pkg::SUM_MIN : sum_ext[47:0];
  assign close_now = open_r && (kind_r || (w_r > cur_win_r));
  assign in_ready = (state_r == F_IDLE);

  always_comb begin
    st_we = 1'b0;
    st_bank = bank_r;
    st_addr = cnt_r[AW-1:0];
    st_data = val_r;
    if (state_r == F_APPLY && !kind_r && !miss_r && !(close_now && !job_ready)) begin
      st_bank = close_now ? ~bank_r : bank_r;
      if (close_now || !open_r) begin
        st_we = 1'b1;
        st_addr = '0;
      end else begin
        st_we = cnt_r < 32'(MAX_WINDOW);
      end
    end
  end

  assign job_valid = (state_r == F_APPLY) && close_now;
  assign job = '{window_index: cur_win_r, sum: sum_r, count: cnt_r, mode: mode_r,
                 bank: bank_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      mode_r <= wsa_pkg::MODE_MEAN;
      len_r <= 31'd100;
      sum_r <= '0;
      cnt_r <= '0;
      cur_win_r <= '0;
      open_r <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == wsa_pkg::CFG_MODE) mode_r <= cfg_wr_data[1:0];
        else len_r <= cfg_wr_data;
      end
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            kind_r <= in_kind;
            miss_r <= in_is_missing;
            val_r <= in_sample_value;
            dq_r <= ((in_position == 32'd0) ? 32'd1 : in_position) - 32'd1;
            dr_r <= '0;
            dc_r <= 6'd32;
            state_r <= in_kind ? F_APPLY : F_DIV;
          end
        end
        F_DIV: begin
          if (dtrial >= {2'b0, (len_r == 31'd0) ? 31'd1 : len_r}) begin
            dr_r <= 32'(dtrial - {2'b0, (len_r == 31'd0) ? 31'd1 : len_r});
            dq_r <= {dq_r[30:0], 1'b1};
          end else begin
            dr_r <= dtrial[31:0];
            dq_r <= {dq_r[30:0], 1'b0};
          end
          dc_r <= dc_r - 6'd1;
          if (dc_r == 6'd1) begin
            state_r <= F_APPLY;
          end
        end
        F_APPLY: begin
          if (kind_r) begin
            if (!open_r) state_r <= F_IDLE;
            else if (job_ready) begin
              sum_r <= '0; cnt_r <= '0; open_r <= 1'b0;
              bank_r <= ~bank_r; state_r <= F_IDLE;
            end
          end else if (!close_now || job_ready) begin
            state_r <= F_IDLE;
            if (close_now || !open_r) begin
              cur_win_r <= dq_r;
              open_r <= 1'b1;
              if (close_now) bank_r <= ~bank_r;
              sum_r <= miss_r ? 48'sd0 : 48'(val_r);
              cnt_r <= miss_r ? 32'd0 : 32'd1;
            end else if (!miss_r) begin
              sum_r <= sum_sat;
              if (cnt_r != 32'hFFFF_FFFF) cnt_r <= cnt_r + 32'd1;
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
  // w_r is the divider quotient once in F_APPLY
  assign w_r = dq_r;
endmodule

@@ hdl/wsa_back.sv @@
// back end: job queue, mean divider, median selection over a banked store
// uses wsa_pkg and wsa_divider
module wsa_back #(
  parameter int MAX_WINDOW = 256,
  localparam int AW = $clog2(MAX_WINDOW)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  wsa_pkg::close_job_t     job,
  output logic                    job_ready,
  input  logic                    st_we,
  input  logic                    st_bank,
  input  logic [AW-1:0]           st_addr,
  input  logic signed [31:0]      st_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             out_window_index,
  output logic signed [47:0]      out_summary_value,
  output logic                    out_empty_window,
  output logic                    out_store_overflow
);
  typedef enum logic [2:0] {B_IDLE, B_DIV, B_SCAN_RD, B_SCAN, B_MED, B_OUT} bstate_t;
  bstate_t state_r;
  // two-entry queue; the bank bit keeps each queued window's values apart
  wsa_pkg::close_job_t q_mem [2];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic q_pop;
  wsa_pkg::close_job_t cur_r;
  logic signed [31:0] store [2**(AW+1)];
  logic signed [31:0] rd_r;
  logic [AW:0] n_r, i_r, j_r, less_r, eq_r;
  logic signed [31:0] cand_r, lo_r;
  logic lo_found_r, need_hi_r;
  logic [AW:0] k_r;
  logic div_start, div_done;
  logic signed [47:0] div_q;
  logic [AW:0] rd_idx;
  logic signed [32:0] med_sum;

  wsa_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(cur_r.sum),
                     .divisor(cur_r.count), .done(div_done), .quotient(div_q));

  // a new window may close only once the previous one is fully summarized,
  // so the bank it used is free again for the front end
  assign job_ready = (q_cnt_r == 2'd0) && (state_r == B_IDLE);
  // start a job only when the output register is free
  assign q_pop = (state_r == B_IDLE) && (q_cnt_r != 2'd0) && (!out_valid || out_ready);
  assign div_start = (state_r == B_DIV) && (i_r == '0);
  // selection: for candidate j count values below and equal; the k-th order
  // statistic is the candidate with less <= k < less+eq
  assign rd_idx = (state_r == B_SCAN_RD) ? j_r : i_r;
  assign med_sum = 33'(lo_r) + 33'(cand_r);

  always_ff @(posedge clk) begin
    if (st_we) store[{st_bank, st_addr}] <= st_data;
    rd_r <= store[{cur_r.bank, rd_idx[AW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) q_mem[q_wp_r] <= job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= '0;
      out_valid <= 1'b0;
      i_r <= '0;
    end else begin
      if (job_valid && job_ready) q_wp_r <= ~q_wp_r;
      q_cnt_r <= q_cnt_r + 2'(job_valid && job_ready) - 2'(q_pop);
      if (state_r == B_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            cur_r <= q_mem[q_rp_r];
            q_rp_r <= ~q_rp_r;
            i_r <= '0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          out_window_index <= cur_r.window_index;
          out_empty_window <= (cur_r.count == 32'd0);
          out_store_overflow <= 1'b0;
          out_summary_value <= '0;
          if (cur_r.count == 32'd0) state_r <= B_OUT;
          else case (cur_r.mode)
            wsa_pkg::MODE_SUM: begin
              out_summary_value <= cur_r.sum; state_r <= B_OUT;
            end
            wsa_pkg::MODE_COUNT: begin
              out_summary_value <= 48'(cur_r.count); state_r <= B_OUT;
            end
            wsa_pkg::MODE_MEDIAN: begin
              out_store_overflow <= cur_r.count > 32'(MAX_WINDOW);
              n_r <= (cur_r.count > 32'(MAX_WINDOW)) ? (AW+1)'(MAX_WINDOW)
                                                      : cur_r.count[AW:0];
              k_r <= (cur_r.count > 32'(MAX_WINDOW)) ? (AW+1)'((MAX_WINDOW - 1) / 2)
                     : (AW+1)'((cur_r.count[AW:0] - (AW+1)'(1)) >> 1);
              need_hi_r <= (cur_r.count > 32'(MAX_WINDOW)) ? (MAX_WINDOW % 2 == 0)
                                                           : ~cur_r.count[0];
              lo_found_r <= 1'b0;
              j_r <= '0;
              state_r <= B_SCAN_RD;
            end
            default: begin
              // divider started on the first cycle, then wait for it
              if (i_r == '0) i_r <= (AW+1)'(1);
              if (div_done) begin
                out_summary_value <= div_q; state_r <= B_OUT;
              end
            end
          endcase
        end
        B_SCAN_RD: begin
          i_r <= '0; less_r <= '0; eq_r <= '0;
          state_r <= B_SCAN;
        end
        B_SCAN: begin
          // latch the candidate first, then pipeline the compares
          if (i_r == '0 && eq_r == '0 && less_r == '0 && !(j_r[AW] & 1'b0)) begin
            cand_r <= rd_r;
            eq_r <= (AW+1)'(1);
            i_r <= (AW+1)'(1);
          end else if (i_r <= n_r) begin
            if (rd_r < cand_r) less_r <= less_r + 1'b1;
            else if (rd_r == cand_r) eq_r <= eq_r + 1'b1;
            i_r <= i_r + 1'b1;
          end else state_r <= B_MED;
        end
        B_MED: begin
          // eq_r counts the candidate itself once (seeded) plus all stored copies
          if (less_r <= k_r && k_r < less_r + eq_r - 1'b1) begin
            if (!lo_found_r && need_hi_r && k_r + 1'b1 < less_r + eq_r - 1'b1) begin
              out_summary_value <= 48'(cand_r); state_r <= B_OUT;
            end else if (!lo_found_r && need_hi_r) begin
              lo_r <= cand_r; lo_found_r <= 1'b1; k_r <= k_r + 1'b1;
              j_r <= '0; state_r <= B_SCAN_RD;
            end else if (lo_found_r) begin
              out_summary_value <= 48'(med_sum >>> 1) +
                                   48'(med_sum[32] & med_sum[0]);
              state_r <= B_OUT;
            end else begin
              out_summary_value <= 48'(cand_r); state_r <= B_OUT;
            end
          end else begin
            j_r <= j_r + 1'b1; state_r <= B_SCAN_RD;
          end
        end
        B_OUT: begin
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/window_summary_aggregator.sv @@
// window summary aggregator, top level
// uses wsa_pkg, wsa_front, wsa_back
// Samples are taken one at a time: each sample passes through the front
// end's bit-serial division of its position by the window length
// (32 steps) plus accept and update; a flush skips the division.
// A window close hands a job to the back end through a short queue; the
// close waits until the back end has finished the previous window, so its
// store bank is free again. The back end produces the mean with a 48-step
// serial divider, and the median by counting selection over the stored
// values, scanning all n stored values for each candidate tried, with a
// second search for an even count whose two middle values differ; sum and
// count go straight to the output register.
// The value store holds MAX_WINDOW entries for each of two banks, so one
// window can fill while an older one is summarized; no clearing pass.
module window_summary_aggregator #(
  parameter int MAX_WINDOW = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [31:0]        in_position,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_is_missing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_window_index,
  output logic signed [47:0] out_summary_value,
  output logic               out_empty_window,
  output logic               out_store_overflow
);
  localparam int AW = $clog2(MAX_WINDOW);
  wsa_pkg::close_job_t job;
  logic job_valid, job_ready, st_we, st_bank;
  logic [AW-1:0] st_addr;
  logic signed [31:0] st_data;

  // front: classify and accumulate
  wsa_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
    .in_valid, .in_ready, .in_kind, .in_position, .in_sample_value, .in_is_missing,
    .job_valid, .job, .job_ready, .st_we, .st_bank, .st_addr, .st_data
  );

  // back: summarize closed windows
  wsa_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk, .rst_n, .job_valid, .job, .job_ready, .st_we, .st_bank, .st_addr, .st_data,
    .out_valid, .out_ready, .out_window_index, .out_summary_value,
    .out_empty_window, .out_store_overflow
  );
endmodule

@@ hdl/wsa_checker.sv @@
// port-level checker for the window summary aggregator, bound to the top
// uses window_summary_aggregator_assert.svh
`include "window_summary_aggregator_assert.svh"
module wsa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] out_summary_value,
  input logic               out_empty_window
);
  `WSA_ASSERT_IMP(a_empty_zero, out_valid && out_empty_window, out_summary_value == 48'sd0)
  `WSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `WSA_ASSERT_NXT(a_in_busy, in_valid && in_ready, !in_ready)
endmodule

bind window_summary_aggregator wsa_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_summary_value, .out_empty_window
);

@@ sim/testbench.sv @@
// self-checking testbench for the window summary aggregator
// depends on wsa_pkg and window_summary_aggregator from hdl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 256;
  localparam int STALL_LIMIT = 1000000;
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_8000_0000_0000;
  localparam bit KIND_SAMPLE = 1'b0;
  localparam bit KIND_FLUSH  = 1'b1;

  // one summary result as the block reports it
  typedef struct packed {
    logic [31:0]        idx;
    logic signed [47:0] val;
    logic               empty;
    logic               ovf;
  } window_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic               cfg_index;
  logic [30:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic [31:0]        in_position;
  logic signed [31:0] in_sample_value;
  logic               in_is_missing;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        out_window_index;
  logic signed [47:0] out_summary_value;
  logic               out_empty_window;
  logic               out_store_overflow;

  window_summary_aggregator u_top (.*);

  // predictor state, mirrors the block after reset
  logic [1:0]  pred_mode = wsa_pkg::MODE_MEAN;
  logic [30:0] pred_len  = 31'd100;
  longint      win_sum   = 0;
  int unsigned win_count = 0;
  int          win_values [STORE_DEPTH];
  logic [31:0] win_index = '0;
  bit          win_open  = 0;

  window_result_t pending_results[$];
  int  error_count = 0;
  bit  quiet_phase = 0;   // no idling on either side while set
  int  idle_cycles = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------
  function automatic void add_sample(int v, bit missing);
    if (missing) return;
    if (win_count < STORE_DEPTH) win_values[win_count] = v;
    win_sum = win_sum + longint'(v);
    if (win_sum > SAT_HI) win_sum = SAT_HI;
    if (win_sum < SAT_LO) win_sum = SAT_LO;
    if (win_count != 32'hFFFF_FFFF) win_count++;
  endfunction

  function automatic longint median_value(int n);
    int sorted [STORE_DEPTH];
    int key;
    int j;
    for (int i = 0; i < n; i++) sorted[i] = win_values[i];
    // insertion sort over the stored values
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    if (n % 2 == 1) return longint'(sorted[n/2]);
    return (longint'(sorted[n/2-1]) + longint'(sorted[n/2])) / 2;
  endfunction

  function automatic window_result_t close_window();
    window_result_t r;
    longint v;
    int n;
    v = 0;
    r.ovf = 1'b0;
    r.empty = (win_count == 0);
    if (!r.empty) begin
      case (pred_mode)
        wsa_pkg::MODE_MEAN:   v = win_sum / longint'(win_count);
        wsa_pkg::MODE_MEDIAN: begin
          n = (win_count > STORE_DEPTH) ? STORE_DEPTH : int'(win_count);
          r.ovf = (win_count > STORE_DEPTH);
          v = median_value(n);
        end
        wsa_pkg::MODE_SUM:    v = win_sum;
        default:              v = longint'(win_count);
      endcase
    end
    r.idx = win_index;
    r.val = v[47:0];
    win_sum = 0;
    win_count = 0;
    return r;
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void predict_item(bit kind, logic [31:0] pos, logic [31:0] val,
                                       bit missing);
    logic [31:0] len;
    logic [31:0] p;
    logic [31:0] w;
    if (kind == KIND_FLUSH) begin
      if (win_open) begin
        pending_results.insert(pending_results.size(), close_window());
        win_open = 0;
      end
      return;
    end
    len = (pred_len == 0) ? 32'd1 : {1'b0, pred_len};   // zero length acts as one
    p = (pos == 0) ? 32'd1 : pos;                         // position zero acts as one
    w = (p - 32'd1) / len;
    if (!win_open) begin
      win_sum = 0;
      win_count = 0;
      win_index = w;
      win_open = 1;
    end else if (w > win_index) begin
      pending_results.insert(pending_results.size(), close_window());
      win_index = w;
    end
    // a backwards position just lands in the open window
    add_sample(int'(val), missing);
  endfunction

  // --------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------
  // all driving happens at the falling edge; the task returns at a falling
  // edge with valid still high so a back-to-back transaction keeps it up
  task automatic send_item(bit kind, logic [31:0] pos, logic [31:0] val, bit missing);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind = kind;
    in_position = pos;
    in_sample_value = val;
    in_is_missing = missing;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(kind, pos, val, missing);
    @(negedge clk);
  endtask

  task automatic send_sample(logic [31:0] pos, logic [31:0] val, bit missing = 0);
    send_item(KIND_SAMPLE, pos, val, missing);
  endtask

  task automatic send_flush();
    send_item(KIND_FLUSH, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // close the open window and let the block drain before a register write;
  // a sample that yields no result may still be in the front end
  task automatic drain_block();
    send_flush();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wr_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == wsa_pkg::CFG_MODE) pred_mode = data[1:0];
    else pred_len = data;
  endtask

  task automatic set_config(logic [1:0] mode, logic [30:0] len);
    drain_block();
    write_reg(wsa_pkg::CFG_MODE, {29'd0, mode});
    write_reg(wsa_pkg::CFG_LEN, len);
  endtask

  // --------------------------------------------------------------------
  // result checker with random back-pressure
  // --------------------------------------------------------------------
  initial begin
    window_result_t exp_r;
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending: window %0d", out_window_index);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_window_index !== exp_r.idx) begin
          $error("window_index expected %0d actual %0d", exp_r.idx, out_window_index);
          error_count++;
        end
        if (out_summary_value !== exp_r.val) begin
          $error("summary_value expected %0d actual %0d", exp_r.val, out_summary_value);
          error_count++;
        end
        if (out_empty_window !== exp_r.empty) begin
          $error("empty_window expected %0b actual %0b", exp_r.empty, out_empty_window);
          error_count++;
        end
        if (out_store_overflow !== exp_r.ovf) begin
          $error("store_overflow expected %0b actual %0b", exp_r.ovf, out_store_overflow);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------
  // default mean mode: edge positions, extreme values, skipped windows
  task automatic test_mean_edges();
    send_flush();                              // flush with nothing open
    send_sample(32'd0, 32'h7FFF_FFFF);         // position zero
    send_sample(32'd1, 32'h8000_0000);
    send_sample(32'd50, 32'h1234_5678, 1);     // missing inside window
    send_sample(32'd100, 32'hFFFF_FFFF);
    send_sample(32'd20, 32'd7);                // backwards position
    send_sample(32'd101, 32'h0001_0000);       // next window
    send_sample(32'd5000, 32'hFFFE_0000);      // skips many windows
    send_flush();
    send_sample(32'd7000, 32'h5555_5555, 1);   // missing sample opens a window
    send_flush();                              // empty window
    send_sample(32'hFFFF_FFFF, 32'hAAAA_AAAA); // top position
    send_flush();
  endtask

  // every summary mode over the same short windows
  task automatic test_each_mode();
    for (int m = 0; m < 4; m++) begin
      set_config(m[1:0], 31'd4);
      send_sample(32'd1, 32'h0003_0000);
      send_sample(32'd2, 32'hFFFF_8000);
      send_sample(32'd3, 32'h7FFF_FFFF);
      send_sample(32'd5, 32'h8000_0001);       // odd and even medians follow
      send_sample(32'd6, 32'd9);
      send_sample(32'd9, 32'd4, 1);
      send_flush();
    end
  endtask

  // window length extremes, including zero which acts as one
  task automatic test_length_extremes();
    set_config(wsa_pkg::MODE_COUNT, 31'd0);
    send_sample(32'd1, 32'd1);
    send_sample(32'd2, 32'd2);
    send_sample(32'd2, 32'd3);
    set_config(wsa_pkg::MODE_SUM, 31'h7FFF_FFFF);
    send_sample(32'd1, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'd1);         // first position of window one
    send_sample(32'hFFFF_FFFF, 32'h8000_0000);
    send_flush();
  endtask

  // median store full: more values than the store holds in one window
  task automatic test_store_overflow();
    set_config(wsa_pkg::MODE_MEDIAN, 31'd1000);
    quiet_phase = 1;
    for (int i = 0; i < STORE_DEPTH + 40; i++)
      send_sample(32'd10 + i, $urandom, ($urandom_range(0, 19) == 0));
    quiet_phase = 0;
    send_flush();
    set_config(wsa_pkg::MODE_MEAN, 31'd1000);
    for (int i = 0; i < STORE_DEPTH + 2; i++)
      send_sample(32'd10 + i, $urandom);
    send_flush();
  endtask

  // random phases with small windows, mostly ordered positions
  task automatic test_random_windows(int total);
    logic [31:0] pos;
    logic [31:0] val;
    logic [30:0] len;
    int sent;
    int phase_items;
    int r;
    sent = 0;
    while (sent < total) begin
      r = $urandom_range(0, 9);
      len = (r < 6) ? 31'($urandom_range(1, 8)) :
            (r < 9) ? 31'($urandom_range(9, 40)) : 31'($urandom_range(0, 3));
      set_config(2'($urandom_range(0, 3)), len);
      quiet_phase = ($urandom_range(0, 3) == 0);
      pos = $urandom;
      phase_items = $urandom_range(20, 80);
      for (int i = 0; i < phase_items; i++) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          default: val = $urandom;
        endcase
        if (r < 5) begin
          send_flush();
        end else begin
          if (r < 9) pos = pos - $urandom_range(0, 30);  // out of order noise
          else pos = pos + $urandom_range(0, 2 * len + 1);
          send_sample(pos, val, ($urandom_range(0, 9) == 0));
        end
      end
      quiet_phase = 0;
      sent += phase_items;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = wsa_pkg::CFG_MODE;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_kind = KIND_SAMPLE;
    in_position = '0;
    in_sample_value = '0;
    in_is_missing = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_mean_edges();
    test_each_mode();
    test_length_extremes();
    test_store_overflow();
    test_random_windows(850);

    send_flush();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
